FILE: hdl/shm_pkg.sv
`default_nettype none
package shm_pkg;

  // Field widths fixed by the item formats
  localparam int SAMPLE_W   = 16;
  localparam int CMD_W      = 2;
  localparam int SEL_W      = 8;
  localparam int NB_W       = 9;
  localparam int OUT_CNT_W  = 24;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 54;
  localparam int PROD_W     = 32;

  // Divider: 24-bit dividend, 16-bit divisor, one quotient bit per step
  localparam int DIV_W      = 24;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STEP_W = 5;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Commands
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Register indexes
  localparam reg_idx_t REG_HIST_LOW    = 2'd0;
  localparam reg_idx_t REG_HIST_HIGH   = 2'd1;
  localparam reg_idx_t REG_BINS_IN_USE = 2'd2;

  // Reset values of the configuration registers
  localparam logic signed [SAMPLE_W-1:0] HIST_LOW_RST  = -16'sd256;
  localparam logic signed [SAMPLE_W-1:0] HIST_HIGH_RST = 16'sd256;
  localparam logic [NB_W-1:0]            BINS_RST      = 9'd64;

  // Status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BADCFG = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/shm_if.sv
`default_nettype none
// Input item channel
interface shm_item_if;
  import shm_pkg::*;
  logic                       valid;
  logic                       ready;
  cmd_t                       command;
  logic signed [SAMPLE_W-1:0] sample;
  logic [SEL_W-1:0]           bin_select;

  modport source (output valid, command, sample, bin_select, input ready);
  modport sink   (input valid, command, sample, bin_select, output ready);
endinterface

// Result item channel
interface shm_result_if;
  import shm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [OUT_CNT_W-1:0]       sample_count;
  logic signed [SUM_W-1:0]    running_sum;
  logic [SQ_W-1:0]            running_square_sum;
  logic signed [SAMPLE_W-1:0] smallest;
  logic signed [SAMPLE_W-1:0] largest;
  logic [SEL_W-1:0]           bin_index;
  logic [OUT_CNT_W-1:0]       bin_count;

  modport source (output valid, status, sample_count, running_sum, running_square_sum,
                  smallest, largest, bin_index, bin_count, input ready);
  modport sink   (input valid, status, sample_count, running_sum, running_square_sum,
                  smallest, largest, bin_index, bin_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/sample_histogram_and_moments.sv
`default_nettype none
// Streaming histogram with running statistics over signed Q8.8 samples. Command add
// updates a saturating count, sum, sum of squares, min, max and one histogram bin and
// reports them; clear zeroes everything; read reports the statistics and one bin.
// One transaction is in work at a time; a finished result waits in the output register
// while the next transaction is taken. After reset the bin memory is swept to zero, one
// entry a cycle, before the first transaction is accepted; a clear command sweeps it the
// same way. An add whose sample lies strictly between the edges runs through the 24-step
// restoring divider (one shared 17-bit compare and 16-bit subtract) that turns the scaled
// offset into a bin; samples at or beyond an edge skip it. Reads, unused commands and an
// add under a bad configuration skip it too; such an add updates nothing.
// Configuration registers: hist_low at 0x0, hist_high at 0x4, bins_in_use at 0x8.
module sample_histogram_and_moments #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [shm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [shm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [shm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  shm_item_if.sink                             item,
  shm_result_if.source                         result
);
  import shm_pkg::*;

  localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BINS - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BIN   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;

  // Configuration
  logic signed [SAMPLE_W-1:0] hist_low;
  logic signed [SAMPLE_W-1:0] hist_high;
  logic [NB_W-1:0]            bins_in_use;

  // Statistics
  logic [COUNT_BITS-1:0]      count_reg;
  logic signed [SUM_W-1:0]    sum_reg;
  logic [SQ_W-1:0]            square_sum_reg;
  logic signed [SAMPLE_W-1:0] min_reg;
  logic signed [SAMPLE_W-1:0] max_reg;

  // Transaction in work
  cmd_t                       cmd_reg;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic [SEL_W-1:0]           sel_reg;
  logic                       sel_ok;
  logic [ADDR_W-1:0]          bin_reg;
  logic [PROD_W-1:0]          sq_reg;
  logic [DIVISOR_W-1:0]       wdt_reg;
  logic [DIVISOR_W-1:0]       rem;
  logic [DIV_W-1:0]           dvd;
  logic [DIV_STEP_W-1:0]      step;
  logic [ADDR_W-1:0]          clr_addr;
  logic                       clr_report;
  logic                       res_status;
  logic [SEL_W-1:0]           res_idx;
  logic [COUNT_BITS-1:0]      res_cnt;

  // Output register
  logic                       out_valid;
  logic                       out_status;
  logic [OUT_CNT_W-1:0]       out_count;
  logic signed [SUM_W-1:0]    out_sum;
  logic [SQ_W-1:0]            out_sq;
  logic signed [SAMPLE_W-1:0] out_min;
  logic signed [SAMPLE_W-1:0] out_max;
  logic [SEL_W-1:0]           out_idx;
  logic [OUT_CNT_W-1:0]       out_cnt;

  // Bin memory
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [COUNT_BITS-1:0]      ram_wdata;
  logic [COUNT_BITS-1:0]      ram_rdata;

  shm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_reg),
    .rdata (ram_rdata)
  );

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[REG_IDX_W+1:2])
      REG_HIST_LOW:    prdata = {16'd0, hist_low};
      REG_HIST_HIGH:   prdata = {16'd0, hist_high};
      REG_BINS_IN_USE: prdata = {23'd0, bins_in_use};
      default:         prdata = '0;
    endcase
  end

  // Effective bin count
  logic [NB_W-1:0] nb;
  logic [NB_W-1:0] nb_last;
  logic            bad_edges;

  always_comb begin
    if (bins_in_use == '0) begin
      nb = NB_W'(1);
    end else if (int'(bins_in_use) > BINS) begin
      nb = NB_W'(BINS);
    end else begin
      nb = bins_in_use;
    end
  end
  assign nb_last   = nb - NB_W'(1);
  assign bad_edges = (hist_low >= hist_high);

  // Offset, edge width and the scaled offset (differences are in range when used)
  logic [SAMPLE_W-1:0]      off_wide;
  logic [SAMPLE_W-1:0]      wdt_wide;
  logic [DIV_W-1:0]         scaled;
  logic signed [PROD_W-1:0] sq_prod;

  assign off_wide = sample_reg - hist_low;
  assign wdt_wide = hist_high - hist_low;
  assign scaled   = DIV_W'(off_wide) * DIV_W'(nb);
  assign sq_prod  = sample_reg * sample_reg;

  // Restoring division step
  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W-1:0] trial_sub;

  assign trial     = {rem, dvd[DIV_W-1]};
  assign fits      = (trial >= {1'b0, wdt_reg});
  assign trial_sub = trial[DIVISOR_W-1:0] - wdt_reg;

  // Statistic updates for one add
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W:0]           sq_wide;
  logic [SQ_W-1:0]         sq_sum_next;
  logic [COUNT_BITS-1:0]   bin_next;
  logic [COUNT_BITS-1:0]   count_next;

  assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                  + {{(SUM_W+1-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  assign sq_wide     = {1'b0, square_sum_reg} + (SQ_W+1)'(sq_reg);
  assign sq_sum_next = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];
  assign bin_next    = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign count_next  = (&count_reg) ? count_reg : count_reg + COUNT_BITS'(1);

  // Memory write: clearing sweep, or bin increment
  assign ram_we    = (state == S_CLEAR) || ((state == S_UPD) && (cmd_reg == CMD_ADD));
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : bin_reg;
  assign ram_wdata = (state == S_CLEAR) ? '0 : bin_next;

  // Handshakes
  logic out_free;
  assign out_free   = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE);

  assign result.valid              = out_valid;
  assign result.status             = out_status;
  assign result.sample_count       = out_count;
  assign result.running_sum        = out_sum;
  assign result.running_square_sum = out_sq;
  assign result.smallest           = out_min;
  assign result.largest            = out_max;
  assign result.bin_index          = out_idx;
  assign result.bin_count          = out_cnt;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      clr_report     <= 1'b0;
      out_valid      <= 1'b0;
      hist_low       <= HIST_LOW_RST;
      hist_high      <= HIST_HIGH_RST;
      bins_in_use    <= BINS_RST;
      count_reg      <= '0;
      sum_reg        <= '0;
      square_sum_reg <= '0;
      min_reg        <= '0;
      max_reg        <= '0;
    end else begin
      // register writes
      if (psel && penable && pwrite) begin
        case (paddr[REG_IDX_W+1:2])
          REG_HIST_LOW:    hist_low    <= pwdata[SAMPLE_W-1:0];
          REG_HIST_HIGH:   hist_high   <= pwdata[SAMPLE_W-1:0];
          REG_BINS_IN_USE: bins_in_use <= pwdata[NB_W-1:0];
          default: ;
        endcase
      end

      // output register
      if ((state == S_FIN) && out_free) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_count  <= OUT_CNT_W'(count_reg);
        out_sum    <= sum_reg;
        out_sq     <= square_sum_reg;
        out_min    <= min_reg;
        out_max    <= max_reg;
        out_idx    <= res_idx;
        out_cnt    <= OUT_CNT_W'(res_cnt);
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr   <= '0;
            clr_report <= 1'b0;
            state      <= clr_report ? S_FIN : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end

        S_IDLE: begin
          if (item.valid) begin
            cmd_reg    <= item.command;
            sample_reg <= item.sample;
            sel_reg    <= item.bin_select;
            sel_ok     <= (int'(item.bin_select) < BINS);
            res_status <= ((item.command == CMD_ADD) && bad_edges) ? STATUS_BADCFG
                                                                   : STATUS_OK;
            res_idx    <= '0;
            res_cnt    <= '0;
            case (item.command)
              CMD_ADD: begin
                state <= bad_edges ? S_FIN : S_PREP;
              end
              CMD_CLEAR: begin
                count_reg      <= '0;
                sum_reg        <= '0;
                square_sum_reg <= '0;
                min_reg        <= '0;
                max_reg        <= '0;
                clr_addr       <= '0;
                clr_report     <= 1'b1;
                state          <= S_CLEAR;
              end
              CMD_READ: begin
                bin_reg <= ADDR_W'(item.bin_select);
                state   <= S_RD;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end

        // square, edge checks and divider load
        S_PREP: begin
          sq_reg  <= PROD_W'(sq_prod);
          wdt_reg <= wdt_wide;
          if (sample_reg <= hist_low) begin
            bin_reg <= '0;
            state   <= S_RD;
          end else if (sample_reg >= hist_high) begin
            bin_reg <= ADDR_W'(nb_last);
            state   <= S_RD;
          end else begin
            dvd   <= scaled;
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end

        // one quotient bit per cycle
        S_DIV: begin
          rem  <= fits ? trial_sub : trial[DIVISOR_W-1:0];
          dvd  <= {dvd[DIV_W-2:0], fits};
          step <= step + DIV_STEP_W'(1);
          if (step == DIV_STEP_W'(DIV_W - 1)) begin
            state <= S_BIN;
          end
        end

        S_BIN: begin
          if (dvd > DIV_W'(nb_last)) begin
            bin_reg <= ADDR_W'(nb_last);
          end else begin
            bin_reg <= ADDR_W'(dvd);
          end
          state <= S_RD;
        end

        // memory read of the selected bin
        S_RD: begin
          state <= S_UPD;
        end

        S_UPD: begin
          if (cmd_reg == CMD_ADD) begin
            if (count_reg == '0) begin
              min_reg <= sample_reg;
              max_reg <= sample_reg;
            end else begin
              if (sample_reg < min_reg) min_reg <= sample_reg;
              if (sample_reg > max_reg) max_reg <= sample_reg;
            end
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            square_sum_reg <= sq_sum_next;
            res_idx        <= SEL_W'(bin_reg);
            res_cnt        <= bin_next;
          end else begin
            res_idx <= sel_reg;
            res_cnt <= sel_ok ? ram_rdata : '0;
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/shm_ram.sv
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle
module shm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import shm_pkg::*;

  localparam int   NUM_BINS       = 256;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   DRAIN_CYCLES   = 40;
  localparam cmd_t CMD_UNUSED     = 2'd3;

  localparam logic [SQ_W-1:0] SQ_LIMIT  = {SQ_W{1'b1}};
  localparam longint          SUM_UPPER = 64'sd549755813887;
  localparam longint          SUM_LOWER = -64'sd549755813888;

  // One result transaction as the block reports it
  typedef struct packed {
    logic                       status;
    logic [OUT_CNT_W-1:0]       sample_count;
    logic signed [SUM_W-1:0]    running_sum;
    logic [SQ_W-1:0]            running_square_sum;
    logic signed [SAMPLE_W-1:0] smallest;
    logic signed [SAMPLE_W-1:0] largest;
    logic [SEL_W-1:0]           bin_index;
    logic [OUT_CNT_W-1:0]       bin_count;
  } report_t;

  // Directed row: fixed set means the typed-in report is the expectation
  typedef struct packed {
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [SEL_W-1:0]           sel;
    logic                       fixed;
    report_t                    want;
  } step_t;

  localparam report_t NO_REPORT = '0;

  // Reset edges: -256, 256, 64 bins
  localparam int DIRECTED_LEN = 19;
  localparam step_t DIRECTED [DIRECTED_LEN] = '{
    '{CMD_READ,   16'sh0000, 8'd0,   1'b1,
      '{1'b0, 24'd0, 40'sd0, 54'd0, 16'sd0, 16'sd0, 8'd0, 24'd0}},
    '{CMD_READ,   16'sh0000, 8'd255, 1'b1,
      '{1'b0, 24'd0, 40'sd0, 54'd0, 16'sd0, 16'sd0, 8'd255, 24'd0}},
    '{CMD_ADD,    16'sd1,    8'd0,   1'b1,
      '{1'b0, 24'd1, 40'sd1, 54'd1, 16'sd1, 16'sd1, 8'd32, 24'd1}},
    '{CMD_ADD,    16'sh8000, 8'd0,   1'b1,
      '{1'b0, 24'd2, -40'sd32767, 54'd1073741825, 16'sh8000, 16'sd1, 8'd0, 24'd1}},
    '{CMD_ADD,    16'sh7FFF, 8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    -16'sd256, 8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    16'sd256,  8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    16'sd255,  8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    -16'sd255, 8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    16'sd0,    8'd0,   1'b0, NO_REPORT},
    '{CMD_ADD,    16'sh5555, 8'hAA,  1'b0, NO_REPORT},
    '{CMD_ADD,    16'shAAAA, 8'h55,  1'b0, NO_REPORT},
    '{CMD_UNUSED, 16'shFFFF, 8'hFF,  1'b0, NO_REPORT},
    '{CMD_READ,   16'sh0000, 8'd63,  1'b0, NO_REPORT},
    '{CMD_READ,   16'sh0000, 8'd32,  1'b0, NO_REPORT},
    '{CMD_READ,   16'sh0000, 8'd0,   1'b0, NO_REPORT},
    '{CMD_CLEAR,  16'sh7FFF, 8'hFF,  1'b1,
      '{1'b0, 24'd0, 40'sd0, 54'd0, 16'sd0, 16'sd0, 8'd0, 24'd0}},
    '{CMD_READ,   16'sh0000, 8'd63,  1'b1,
      '{1'b0, 24'd0, 40'sd0, 54'd0, 16'sd0, 16'sd0, 8'd63, 24'd0}},
    '{CMD_READ,   16'sh0000, 8'd0,   1'b1,
      '{1'b0, 24'd0, 40'sd0, 54'd0, 16'sd0, 16'sd0, 8'd0, 24'd0}}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  shm_item_if   item_ch ();
  shm_result_if result_ch ();

  sample_histogram_and_moments dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  // Shadow copy of the configuration and of the accumulated statistics
  logic signed [SAMPLE_W-1:0] edge_lo;
  logic signed [SAMPLE_W-1:0] edge_hi;
  logic [NB_W-1:0]            bins_set;
  logic [OUT_CNT_W-1:0]       n_samples;
  logic signed [SUM_W-1:0]    total;
  logic [SQ_W-1:0]            total_sq;
  logic signed [SAMPLE_W-1:0] min_seen;
  logic signed [SAMPLE_W-1:0] max_seen;
  logic [OUT_CNT_W-1:0]       bin_tally [NUM_BINS];

  report_t pending_reports [$];
  int      mismatches;
  int      idle_pct;
  int      hold_left;
  int      quiet_cycles;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Effective bin count of the current setting
  function automatic int bins_effective();
    int nb;
    nb = bins_set;
    if (nb == 0) nb = 1;
    if (nb > NUM_BINS) nb = NUM_BINS;
    return nb;
  endfunction

  // Applies one command to the shadow state and returns the report it yields
  function automatic report_t apply_command(cmd_t cmd, logic signed [SAMPLE_W-1:0] value,
                                            logic [SEL_W-1:0] sel);
    report_t r;
    longint  lo;
    longint  hi;
    longint  v;
    longint  nb;
    longint  bin;
    longint  sum_next;
    logic [SQ_W-1:0] sq;
    r = '0;
    lo = edge_lo;
    hi = edge_hi;
    v = value;
    nb = bins_effective();
    case (cmd)
      CMD_ADD: begin
        if (lo >= hi) begin
          r.status = STATUS_BADCFG;
        end else begin
          if (v <= lo) bin = 0;
          else if (v >= hi) bin = nb - 1;
          else begin
            bin = ((v - lo) * nb) / (hi - lo);
            if (bin > nb - 1) bin = nb - 1;
          end
          if (n_samples == 0) begin
            min_seen = value;
            max_seen = value;
          end else begin
            if (value < min_seen) min_seen = value;
            if (value > max_seen) max_seen = value;
          end
          if (n_samples != '1) n_samples = n_samples + 1'b1;
          sum_next = longint'(total) + v;
          if (sum_next > SUM_UPPER) sum_next = SUM_UPPER;
          if (sum_next < SUM_LOWER) sum_next = SUM_LOWER;
          total = sum_next[SUM_W-1:0];
          sq = SQ_W'(v * v);
          if (total_sq > SQ_LIMIT - sq) total_sq = SQ_LIMIT;
          else total_sq = total_sq + sq;
          if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
          r.status = STATUS_OK;
          r.bin_index = bin[SEL_W-1:0];
          r.bin_count = bin_tally[bin];
        end
      end
      CMD_CLEAR: begin
        n_samples = '0;
        total = '0;
        total_sq = '0;
        min_seen = '0;
        max_seen = '0;
        for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
      end
      CMD_READ: begin
        r.bin_index = sel;
        r.bin_count = bin_tally[sel];
      end
      default: ;
    endcase
    r.sample_count = n_samples;
    r.running_sum = total;
    r.running_square_sum = total_sq;
    r.smallest = min_seen;
    r.largest = max_seen;
    return r;
  endfunction

  // Drives one item transaction and records what it should produce
  task automatic send_item(cmd_t cmd, logic signed [SAMPLE_W-1:0] value,
                           logic [SEL_W-1:0] sel, logic fixed, report_t want);
    int gap;
    report_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.sample <= value;
    item_ch.bin_select <= sel;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    r = apply_command(cmd, value, sel);
    if (fixed) r = want;
    pending_reports.insert(pending_reports.size(), r);
  endtask

  // Register write over the configuration port
  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HIST_LOW:    edge_lo = value[SAMPLE_W-1:0];
      REG_HIST_HIGH:   edge_hi = value[SAMPLE_W-1:0];
      REG_BINS_IN_USE: bins_set = value[NB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop the input, wait for every outstanding result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sample biased toward the edges and the inside of the histogram range
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int pick;
    int lo;
    int hi;
    pick = $urandom_range(0, 99);
    lo = edge_lo;
    hi = edge_hi;
    if (pick < 40 && hi > lo) return SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
    if (pick < 50) return SAMPLE_W'(lo + int'($urandom_range(0, 4)) - 2);
    if (pick < 60) return SAMPLE_W'(hi + int'($urandom_range(0, 4)) - 2);
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // New setting, then a burst of random transactions under it
  task automatic run_phase(int lo, int hi, int nb, int idle, int count);
    int   pick;
    cmd_t cmd;
    logic [SEL_W-1:0] sel;
    wait_drained();
    write_reg(REG_HIST_LOW, APB_DATA_W'(lo));
    write_reg(REG_HIST_HIGH, APB_DATA_W'(hi));
    write_reg(REG_BINS_IN_USE, APB_DATA_W'(nb));
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) cmd = CMD_ADD;
      else if (pick < 93) cmd = CMD_READ;
      else if (pick < 96) cmd = CMD_CLEAR;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) < 7) sel = SEL_W'($urandom_range(0, bins_effective() - 1));
      else sel = SEL_W'($urandom_range(0, NUM_BINS - 1));
      send_item(cmd, pick_sample(), sel, 1'b0, NO_REPORT);
    end
  endtask

  // Result side: random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      hold_left = pick_gap();
      result_ch.ready <= (hold_left == 0);
      if (hold_left > 0) hold_left = hold_left - 1;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, result_ch.status);
        check_field("sample_count", want.sample_count, result_ch.sample_count);
        check_field("running_sum", want.running_sum, result_ch.running_sum);
        check_field("running_square_sum", want.running_square_sum,
                    result_ch.running_square_sum);
        check_field("smallest", want.smallest, result_ch.smallest);
        check_field("largest", want.largest, result_ch.largest);
        check_field("bin_index", want.bin_index, result_ch.bin_index);
        check_field("bin_count", want.bin_count, result_ch.bin_count);
      end
    end
  end

  // Watchdog: cycles without any transaction on any port
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    int lo;
    int w;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_ADD;
    item_ch.sample = '0;
    item_ch.bin_select = '0;
    result_ch.ready = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    idle_pct = 30;
    edge_lo = HIST_LOW_RST;
    edge_hi = HIST_HIGH_RST;
    bins_set = BINS_RST;
    n_samples = '0;
    total = '0;
    total_sq = '0;
    min_seen = '0;
    max_seen = '0;
    for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset setting
    for (int i = 0; i < DIRECTED_LEN; i++)
      send_item(DIRECTED[i].cmd, DIRECTED[i].sample, DIRECTED[i].sel,
                DIRECTED[i].fixed, DIRECTED[i].want);

    // Extreme and degenerate settings
    run_phase(-32768, 32767, 256, 30, 90);
    run_phase(0, 1, 1, 0, 60);
    run_phase(100, 100, 64, 30, 25);
    run_phase(32767, -32768, 511, 40, 25);
    run_phase(-32768, -32767, 0, 30, 60);
    run_phase(-1000, 3000, 511, 0, 80);

    // Random settings, mostly valid
    for (int p = 0; p < 6; p++) begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 40);
      else w = $urandom_range(1, 65535);
      if ($urandom_range(0, 9) == 0) w = -int'($urandom_range(0, 100));
      if (lo + w > 32767) w = 32767 - lo;
      run_phase(lo, lo + w, $urandom_range(1, 300), (p % 3 == 0) ? 0 : 35, 80);
    end

    wait_drained();

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/shm_pkg.sv
hdl/shm_if.sv
hdl/shm_ram.sv
hdl/sample_histogram_and_moments.sv
test/testbench.sv
